// ===== rtl/usp_pkg.sv =====
`timescale 1ns / 1ps
// usp_pkg: types, codes and helper functions of the URL split parser.
// No dependencies; imported by url_split_parser_top.
package usp_pkg;

    // parse phase
    typedef enum logic [1:0] {
        PH_PROTOCOL = 2'd0,
        PH_HOST     = 2'd1,
        PH_PORT     = 2'd2,
        PH_RESOURCE = 2'd3
    } t_phase;

    // result kinds
    localparam logic [1:0] KIND_PROTOCOL = 2'd0;
    localparam logic [1:0] KIND_HOST     = 2'd1;
    localparam logic [1:0] KIND_RESOURCE = 2'd2;
    localparam logic [1:0] KIND_SUMMARY  = 2'd3;

    // summary status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SEP  = 2'd1;
    localparam logic [1:0] ST_NO_PROT = 2'd2;

    localparam logic [7:0]  CH_COLON  = 8'h3A;
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [2:0]  HTTPS_LEN  = 3'd5;
    localparam int          MAX_RESULTS = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] port_number;
        logic        secure;
        logic [1:0]  status;
        logic        last_of_url;
    } t_item;

    // one character of "https" by position
    function automatic logic [7:0] https_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h68;  // h
            3'd1:    c = 8'h74;  // t
            3'd2:    c = 8'h74;  // t
            3'd3:    c = 8'h70;  // p
            3'd4:    c = 8'h73;  // s
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // track the case-insensitive "https" compare for one protocol byte
    function automatic logic [3:0] https_track(input logic [2:0] idx, input logic mis,
                                               input logic [7:0] b);
        logic [7:0] lc;
        logic [2:0] n_idx;
        logic       n_mis;
        lc    = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
        n_idx = idx;
        n_mis = mis;
        if (idx < HTTPS_LEN) begin
            if (lc != https_char(idx)) n_mis = 1'b1;
            n_idx = idx + 3'd1;
        end else begin
            n_mis = 1'b1;
        end
        return {n_idx, n_mis};
    endfunction

    function automatic t_item byte_item(input logic [1:0] kind, input logic [7:0] b);
        t_item it;
        it           = '0;
        it.kind      = kind;
        it.data_byte = b;
        return it;
    endfunction

endpackage

// ===== rtl/url_split_parser_top.sv =====
`timescale 1ns / 1ps
// url_split_parser_top: URL splitter, protocol / host / resource tagging with port summary.
// Depends on usp_pkg.
//
// Results are registered twice: first into the result buffer, then into the output register.
// Throughput: one input beat per cycle while each beat yields at most one result and the output
//   is not stalled; a beat that yields more (up to 4: held separator bytes, the byte, the summary)
//   holds off the next beat while the single output register drains the buffer, one result a cycle.
// Reset: synchronous, active low; clears phase, parse state, buffer count and output valid.
module url_split_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] url_byte
    input  logic        i_s_tlast,   // is_final
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] data_byte, [23:8] port_number, [24] secure,
                                     // [26:25] status, [31:27] zero
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast    // last_of_url
);
    import usp_pkg::*;

    // parse state
    t_phase      r_phase;
    logic [1:0]  r_sep;          // bytes of "://" currently held
    logic        r_seen;         // a protocol byte has gone out
    logic [2:0]  r_hidx;
    logic        r_hmis;
    logic [15:0] r_pacc;
    logic        r_pgiven;
    logic        r_pend;         // port digits ended

    // result buffer: all results of one accepted beat, drained in order
    t_item       r_buf [MAX_RESULTS];
    logic [2:0]  r_rem;          // results still in buffer
    logic [1:0]  r_rd;           // next slot to drain

    // output register
    t_item       r_out;
    logic        r_out_vld;

    // next values from the incoming beat
    t_phase      n_phase;
    logic [1:0]  n_sep;
    logic        n_seen;
    logic [2:0]  n_hidx;
    logic        n_hmis;
    logic [15:0] n_pacc;
    logic        n_pgiven;
    logic        n_pend;
    t_item       n_res [MAX_RESULTS];
    logic [2:0]  n_cnt;

    logic out_free, move, accept;

    assign out_free   = !r_out_vld || i_m_tready;
    assign move       = out_free && (r_rem != 3'd0);
    assign o_s_tready = (r_rem == 3'd0) || ((r_rem == 3'd1) && out_free);
    assign accept     = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'b0, r_out.status, r_out.secure, r_out.port_number, r_out.data_byte};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last_of_url;

    // one pass over the incoming byte: up to four results and the next parse state
    always_comb begin
        logic [7:0]  b;
        logic [19:0] prod;
        logic [3:0]  ht;
        t_item       sum;
        b        = i_s_tdata;
        n_phase  = r_phase;
        n_sep    = r_sep;
        n_seen   = r_seen;
        n_hidx   = r_hidx;
        n_hmis   = r_hmis;
        n_pacc   = r_pacc;
        n_pgiven = r_pgiven;
        n_pend   = r_pend;
        n_cnt    = 3'd0;
        prod     = '0;
        ht       = '0;
        sum      = '0;
        for (int k = 0; k < MAX_RESULTS; k++) n_res[k] = '0;

        case (r_phase)
            PH_PROTOCOL: begin
                if (r_sep == 2'd1) begin
                    if (b == CH_SLASH) begin
                        n_sep = 2'd2;
                    end else begin
                        // release held ':'
                        ht = https_track(n_hidx, n_hmis, CH_COLON);
                        {n_hidx, n_hmis} = ht;
                        n_seen = 1'b1;
                        n_res[n_cnt[1:0]] = byte_item(KIND_PROTOCOL, CH_COLON);
                        n_cnt = n_cnt + 3'd1;
                        if (b != CH_COLON) begin
                            n_sep = 2'd0;
                            ht = https_track(n_hidx, n_hmis, b);
                            {n_hidx, n_hmis} = ht;
                            n_res[n_cnt[1:0]] = byte_item(KIND_PROTOCOL, b);
                            n_cnt = n_cnt + 3'd1;
                        end
                    end
                end else if (r_sep == 2'd2) begin
                    if (b == CH_SLASH) begin
                        n_sep   = 2'd0;
                        n_phase = PH_HOST;
                    end else begin
                        // release held ":/"
                        ht = https_track(n_hidx, n_hmis, CH_COLON);
                        {n_hidx, n_hmis} = ht;
                        n_res[n_cnt[1:0]] = byte_item(KIND_PROTOCOL, CH_COLON);
                        n_cnt = n_cnt + 3'd1;
                        ht = https_track(n_hidx, n_hmis, CH_SLASH);
                        {n_hidx, n_hmis} = ht;
                        n_res[n_cnt[1:0]] = byte_item(KIND_PROTOCOL, CH_SLASH);
                        n_cnt = n_cnt + 3'd1;
                        n_seen = 1'b1;
                        if (b == CH_COLON) begin
                            n_sep = 2'd1;
                        end else begin
                            n_sep = 2'd0;
                            ht = https_track(n_hidx, n_hmis, b);
                            {n_hidx, n_hmis} = ht;
                            n_res[n_cnt[1:0]] = byte_item(KIND_PROTOCOL, b);
                            n_cnt = n_cnt + 3'd1;
                        end
                    end
                end else begin
                    if (b == CH_COLON) begin
                        n_sep = 2'd1;
                    end else begin
                        ht = https_track(n_hidx, n_hmis, b);
                        {n_hidx, n_hmis} = ht;
                        n_seen = 1'b1;
                        n_res[n_cnt[1:0]] = byte_item(KIND_PROTOCOL, b);
                        n_cnt = n_cnt + 3'd1;
                    end
                end
            end
            PH_HOST: begin
                if (b == CH_SLASH) begin
                    n_phase = PH_RESOURCE;
                    n_res[n_cnt[1:0]] = byte_item(KIND_RESOURCE, b);
                    n_cnt = n_cnt + 3'd1;
                end else if (b == CH_COLON) begin
                    n_phase  = PH_PORT;
                    n_pgiven = 1'b1;
                end else begin
                    n_res[n_cnt[1:0]] = byte_item(KIND_HOST, b);
                    n_cnt = n_cnt + 3'd1;
                end
            end
            PH_PORT: begin
                if (b == CH_SLASH) begin
                    n_phase = PH_RESOURCE;
                    n_res[n_cnt[1:0]] = byte_item(KIND_RESOURCE, b);
                    n_cnt = n_cnt + 3'd1;
                end else if (!r_pend && b >= CH_ZERO && b <= CH_NINE) begin
                    // acc * 10 + digit, saturating
                    prod = {1'b0, r_pacc, 3'b0} + {3'b0, r_pacc, 1'b0}
                         + {16'b0, b[3:0]};
                    n_pacc = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
                end else begin
                    n_pend = 1'b1;
                end
            end
            PH_RESOURCE: begin
                n_res[n_cnt[1:0]] = byte_item(KIND_RESOURCE, b);
                n_cnt = n_cnt + 3'd1;
            end
            default: begin
                n_phase = PH_PROTOCOL;
            end
        endcase

        if (i_s_tlast) begin
            sum             = '0;
            sum.kind        = KIND_SUMMARY;
            sum.last_of_url = 1'b1;
            if (n_phase == PH_PROTOCOL) begin
                // no separator: release whatever part of it is held
                if (n_sep != 2'd0) begin
                    n_res[n_cnt[1:0]] = byte_item(KIND_PROTOCOL, CH_COLON);
                    n_cnt = n_cnt + 3'd1;
                end
                if (n_sep == 2'd2) begin
                    n_res[n_cnt[1:0]] = byte_item(KIND_PROTOCOL, CH_SLASH);
                    n_cnt = n_cnt + 3'd1;
                end
                sum.status = ST_NO_SEP;
            end else if (!n_seen) begin
                sum.status = ST_NO_PROT;
            end else begin
                sum.status      = ST_OK;
                sum.secure      = !n_hmis && (n_hidx == HTTPS_LEN);
                sum.port_number = n_pgiven ? n_pacc : (sum.secure ? PORT_HTTPS : PORT_HTTP);
            end
            n_res[n_cnt[1:0]] = sum;
            n_cnt = n_cnt + 3'd1;
            // back to reset state for the next URL
            n_phase  = PH_PROTOCOL;
            n_sep    = 2'd0;
            n_seen   = 1'b0;
            n_hidx   = 3'd0;
            n_hmis   = 1'b0;
            n_pacc   = 16'd0;
            n_pgiven = 1'b0;
            n_pend   = 1'b0;
        end
    end

    // parse state and buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PROTOCOL;
            r_sep     <= 2'd0;
            r_seen    <= 1'b0;
            r_hidx    <= 3'd0;
            r_hmis    <= 1'b0;
            r_pacc    <= 16'd0;
            r_pgiven  <= 1'b0;
            r_pend    <= 1'b0;
            r_rem     <= 3'd0;
            r_rd      <= 2'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (move) begin
                r_out_vld <= 1'b1;
                r_rd      <= r_rd + 2'd1;
                r_rem     <= r_rem - 3'd1;
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
            // a new beat refills the buffer; any old slot still left was drained above
            if (accept) begin
                r_phase  <= n_phase;
                r_sep    <= n_sep;
                r_seen   <= n_seen;
                r_hidx   <= n_hidx;
                r_hmis   <= n_hmis;
                r_pacc   <= n_pacc;
                r_pgiven <= n_pgiven;
                r_pend   <= n_pend;
                r_rem    <= n_cnt;
                r_rd     <= 2'd0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= r_buf[r_rd];
        end
        if (accept) begin
            for (int k = 0; k < MAX_RESULTS; k++) r_buf[k] <= n_res[k];
        end
    end

endmodule
